// File: rtl/core/ist_pkg.sv
// Package for the indentation normalizer: character codes, field widths and the
// command record that the front hands to the back through the queue.
// No dependencies.
package ist_pkg;

  // Character codes that the front classifies.
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;

  // Widths fixed by the stream format and the deepest allowed indentation.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SpaceW  = 8;
  localparam int unsigned TabCntW = 6;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxTabsDef    = 63;
  localparam int unsigned QueueDepthDef = 4;

  // One command: an error beat, or a run of tabs followed by an optional byte.
  typedef struct packed {
    logic               err;
    logic [TabCntW-1:0] tabs;
    logic               emit;
    logic [ByteW-1:0]   data;
  } ist_cmd_t;

endpackage

// File: rtl/core/ist_front.sv
// Front of the indentation normalizer: tracks line-start state and the space
// count, and turns accepted bytes that give output into queue commands. Uses ist_pkg.
module ist_front import ist_pkg::*; #(
  parameter int unsigned MaxTabs = MaxTabsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             end_of_text_i,
  output logic             push_o,
  output ist_cmd_t         cmd_o,
  input  logic             full_i
);

  // Largest space count that still maps onto whole tabs.
  localparam logic [SpaceW-1:0] Limit = SpaceW'(4 * MaxTabs);

  logic              at_line_start_q, at_line_start_d;
  logic [SpaceW-1:0] space_count_q, space_count_d;
  logic              error_hold_q, error_hold_d;
  logic              accept;
  logic              want_push;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && want_push;

  // Classify the byte and work out the next line state.
  always_comb begin
    logic              als;
    logic [SpaceW-1:0] sc;
    logic              err;
    als       = at_line_start_q;
    sc        = space_count_q;
    err       = 1'b0;
    cmd_o     = '0;
    cmd_o.data = text_byte_i;
    want_push = 1'b0;
    at_line_start_d = at_line_start_q;
    space_count_d   = space_count_q;
    error_hold_d    = error_hold_q;

    if (!error_hold_q) begin
      // The first byte that is neither tab nor space closes the indentation.
      if (als && text_byte_i != ChTab && text_byte_i != ChSpace) begin
        als = 1'b0;
        if (sc[1:0] != 2'b00 || sc > Limit) begin
          err = 1'b1;
        end else begin
          cmd_o.tabs = sc[SpaceW-1:2];
          sc = '0;
        end
      end
      if (err) begin
        cmd_o.err = 1'b1;
      end else begin
        if (text_byte_i == ChLf) begin
          als = 1'b1;
        end
        if (text_byte_i != ChCr) begin
          if (als && text_byte_i == ChSpace) begin
            if (sc <= Limit) begin
              sc = SpaceW'(sc + 1'b1);
            end
          end else begin
            cmd_o.emit = 1'b1;
          end
        end
      end
      want_push       = err || cmd_o.emit || (cmd_o.tabs != '0);
      at_line_start_d = als;
      space_count_d   = sc;
      error_hold_d    = err;
    end

    // The last byte of a text always returns the state to reset.
    if (end_of_text_i) begin
      at_line_start_d = 1'b1;
      space_count_d   = '0;
      error_hold_d    = 1'b0;
    end
  end

  // Line state registers, updated once per accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_line_start_q <= 1'b1;
      space_count_q   <= '0;
      error_hold_q    <= 1'b0;
    end else if (accept) begin
      at_line_start_q <= at_line_start_d;
      space_count_q   <= space_count_d;
      error_hold_q    <= error_hold_d;
    end
  end

  // Once an error is held, no byte may produce another command.
  a_no_push_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_hold_q |-> !push_o)
    else $error("command pushed while an error is held");

endmodule

// File: rtl/core/ist_fifo.sv
// Short command queue between front and back of the indentation normalizer.
// Register-based circular buffer. Uses ist_pkg.
module ist_fifo import ist_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ist_cmd_t cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output ist_cmd_t cmd_o,
  output logic     valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ist_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage carries payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // The fill count never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill count out of range");

endmodule

// File: rtl/core/ist_back.sv
// Back of the indentation normalizer: expands the command at the queue head into output
// beats, one per cycle while not stalled, into an output register. Uses ist_pkg.
module ist_back import ist_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  ist_cmd_t         cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             format_error_o,
  output logic             last_of_run_o
);

  logic               out_valid_q, out_valid_d;
  logic [ByteW-1:0]   out_byte_q, out_byte_d;
  logic               format_error_q, format_error_d;
  logic               last_of_run_q, last_of_run_d;
  logic [TabCntW-1:0] tab_idx_q, tab_idx_d;
  logic               load;

  // A new beat is formed whenever a command waits and the output register is free or draining.
  assign load = cmd_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_byte_d     = out_byte_q;
    format_error_d = format_error_q;
    last_of_run_d  = last_of_run_q;
    tab_idx_d      = tab_idx_q;
    pop_o          = 1'b0;
    out_valid_d    = out_valid_q && out_stall_i;
    if (load) begin
      out_valid_d = 1'b1;
      if (cmd_i.err) begin
        out_byte_d     = '0;
        format_error_d = 1'b1;
        last_of_run_d  = 1'b1;
      end else if (tab_idx_q < cmd_i.tabs) begin
        out_byte_d     = ChTab;
        format_error_d = 1'b0;
        last_of_run_d  = (TabCntW'(tab_idx_q + 1'b1) == cmd_i.tabs) && !cmd_i.emit;
      end else begin
        out_byte_d     = cmd_i.data;
        format_error_d = 1'b0;
        last_of_run_d  = 1'b1;
      end
      // The last beat of a command retires it from the queue.
      if (last_of_run_d) begin
        pop_o     = 1'b1;
        tab_idx_d = '0;
      end else begin
        tab_idx_d = TabCntW'(tab_idx_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      tab_idx_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      tab_idx_q   <= tab_idx_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_byte_q     <= out_byte_d;
    format_error_q <= format_error_d;
    last_of_run_q  <= last_of_run_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign format_error_o = format_error_q;
  assign last_of_run_o  = last_of_run_q;

  // A partly expanded command never runs past its tab count; it sits at the
  // count only while the trailing byte is still to be sent.
  a_tab_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && !cmd_i.err && tab_idx_q != '0) |-> (tab_idx_q <= cmd_i.tabs))
    else $error("tab index ran past the command's tab count");

  // An error beat always closes its item.
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && format_error_o) |-> last_of_run_o)
    else $error("error beat not marked as last of run");

  // The tab index only advances while the queue head is present.
  a_idx_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_valid_i) |=> (tab_idx_q == $past(tab_idx_q)))
    else $error("tab index moved without a command");

endmodule

// File: rtl/core/indent_spaces_to_tabs.sv
// Indentation normalizer top level: front (classify), command queue, back (expand).
// Path: an accepted byte's command is registered in the queue, then its beats in the output register.
// Throughput: one byte per cycle while each byte gives at most one beat and the output
// does not stall; a byte that closes an indentation of k tabs keeps the back busy for k
// tab beats, plus its own byte if emitted, and the queue (QueueDepth commands) absorbs that until the input stalls.
// Reset: at line start, no spaces counted, no error held, queue and output empty.
module indent_spaces_to_tabs import ist_pkg::*; #(
  parameter int unsigned MaxTabs    = MaxTabsDef,
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             end_of_text_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             format_error_o,
  output logic             last_of_run_o
);

  logic     push;
  logic     full;
  logic     pop;
  logic     head_valid;
  ist_cmd_t push_cmd;
  ist_cmd_t head_cmd;

  ist_front #(
    .MaxTabs(MaxTabs)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .full_i       (full)
  );

  ist_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .valid_o(head_valid)
  );

  ist_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (head_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .format_error_o(format_error_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: tb/sv/ist_checker.sv
// Checker for the indentation normalizer: watches both channels, predicts the
// normalized beats of every accepted text byte and compares them in order.
// Depends on ist_pkg for the character codes and the field widths.
module ist_checker import ist_pkg::*; #(
  parameter int unsigned MaxTabs = MaxTabsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             end_of_text_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [ByteW-1:0] out_byte_i,
  input  logic             format_error_i,
  input  logic             last_of_run_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  localparam int unsigned SpacesPerTab = 4;
  localparam int unsigned SpaceLimit   = SpacesPerTab * MaxTabs;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             err;
    logic             last;
  } norm_beat_t;

  // Beats still owed by the block, oldest first.
  norm_beat_t owed_beats_q[$];

  // Shadow of the normalizer state.
  logic              in_indent   = 1'b1;
  logic [SpaceW-1:0] spaces_seen = '0;
  logic              err_latched = 1'b0;

  int unsigned fails   = 0;
  int unsigned pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic void restart_text();
    in_indent   = 1'b1;
    spaces_seen = '0;
    err_latched = 1'b0;
  endfunction

  // Works out the beats that one text byte causes and queues them.
  task automatic normalize_byte(input logic [ByteW-1:0] b, input logic eot);
    norm_beat_t line_beats[$];
    int unsigned tabs;
    line_beats = {};
    if (err_latched) begin
      if (eot) restart_text();
      return;
    end
    // A byte other than tab or space closes the indentation.
    if (in_indent && b != ChTab && b != ChSpace) begin
      in_indent = 1'b0;
      if ((spaces_seen % SpacesPerTab) != 0 || spaces_seen > SpaceLimit) begin
        owed_beats_q.push_back('{data: '0, err: 1'b1, last: 1'b1});
        if (eot) restart_text();
        else err_latched = 1'b1;
        return;
      end
      tabs = spaces_seen / SpacesPerTab;
      repeat (tabs) line_beats.push_back('{data: ChTab, err: 1'b0, last: 1'b0});
      spaces_seen = '0;
    end
    if (b == ChLf) in_indent = 1'b1;
    // Carriage returns vanish; spaces inside the indentation are only counted.
    if (b != ChCr) begin
      if (in_indent && b == ChSpace) begin
        if (spaces_seen <= SpaceLimit) spaces_seen++;
      end else begin
        line_beats.push_back('{data: b, err: 1'b0, last: 1'b0});
      end
    end
    if (line_beats.size() > 0) line_beats[line_beats.size()-1].last = 1'b1;
    foreach (line_beats[i]) owed_beats_q.push_back(line_beats[i]);
    if (eot) restart_text();
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    fails++;
    $display("%0t: ist_checker: %s mismatch, expected %0h, actual %0h",
             $time, field, want, got);
  endtask

  // Input beats feed the prediction; output beats are checked against it.
  always @(posedge clk_i or negedge rst_ni) begin
    norm_beat_t want_beat;
    if (!rst_ni) begin
      restart_text();
      owed_beats_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) normalize_byte(text_byte_i, end_of_text_i);
      if (out_valid_i && !out_stall_i) begin
        if (owed_beats_q.size() == 0) begin
          fails++;
          $display("%0t: ist_checker: unexpected beat, expected none, actual %0h/%b/%b",
                   $time, out_byte_i, format_error_i, last_of_run_i);
        end else begin
          want_beat = owed_beats_q.pop_front();
          // An error beat carries a zero byte.
          if (out_byte_i !== want_beat.data)
            report_mismatch("out_byte", want_beat.data, out_byte_i);
          if (format_error_i !== want_beat.err)
            report_mismatch("format_error", want_beat.err, format_error_i);
          if (last_of_run_i !== want_beat.last)
            report_mismatch("last_of_run", want_beat.last, last_of_run_i);
        end
      end
    end
    pending = owed_beats_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the indentation normalizer: clock, reset, text stimulus with
// random gaps and stalls, and the verdict. Depends on ist_pkg, the block and ist_checker.
module tb_top import ist_pkg::*;;

  localparam int unsigned MaxTabs     = MaxTabsDef;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned WaitLimit   = 200000;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic [ByteW-1:0] text_byte   = '0;
  logic             end_of_text = 1'b0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic [ByteW-1:0] out_byte;
  logic             format_error;
  logic             last_of_run;
  int unsigned      fail_count;
  int unsigned      pending;

  // Text bytes of the next text, sent in order with end of text on the last one.
  logic [ByteW-1:0] text_q[$];
  int unsigned      items_sent = 0;
  logic             quiet      = 1'b0;

  always #5 clk = ~clk;

  indent_spaces_to_tabs #(
    .MaxTabs(MaxTabs)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .text_byte_i   (text_byte),
    .end_of_text_i (end_of_text),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte_o    (out_byte),
    .format_error_o(format_error),
    .last_of_run_o (last_of_run)
  );

  ist_checker #(
    .MaxTabs(MaxTabs)
  ) i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .text_byte_i   (text_byte),
    .end_of_text_i (end_of_text),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte_i    (out_byte),
    .format_error_i(format_error),
    .last_of_run_i (last_of_run),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Idle length: mostly none or short, now and then long, never in a quiet stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Offers one byte and holds it until the block takes the beat.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic is_last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= b;
    end_of_text <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // Builds a random text: mostly indented lines, sometimes cut short or pure noise.
  task automatic build_text();
    int unsigned r, spaces, tabs_mixed, keep;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 24)) text_q.push_back(ByteW'($urandom()));
      return;
    end
    repeat ($urandom_range(1, 5)) begin
      r = $urandom_range(0, 99);
      if (r < 75) spaces = 4 * $urandom_range(0, 8);
      else if (r < 90) spaces = $urandom_range(1, 19);
      else spaces = 0;
      tabs_mixed = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      // Tabs may sit anywhere among the indentation spaces.
      repeat (spaces) begin
        if (tabs_mixed > 0 && $urandom_range(0, 3) == 0) begin
          text_q.push_back(ChTab);
          tabs_mixed--;
        end
        text_q.push_back(ChSpace);
      end
      repeat (tabs_mixed) text_q.push_back(ChTab);
      repeat ($urandom_range(0, 12)) begin
        r = $urandom_range(0, 99);
        if (r < 65) text_q.push_back(ByteW'($urandom_range(8'h21, 8'h7E)));
        else if (r < 77) text_q.push_back(ChSpace);
        else if (r < 83) text_q.push_back(ChTab);
        else if (r < 88) text_q.push_back(ChCr);
        else text_q.push_back(ByteW'($urandom_range(0, 255)));
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        text_q.push_back(ChLf);
      end else if (r < 85) begin
        text_q.push_back(ChCr);
        text_q.push_back(ChLf);
      end
    end
    // Ending the text early leaves spaces pending or a line half done.
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, text_q.size());
      while (text_q.size() > keep) void'(text_q.pop_back());
    end
  endtask

  // Output stall: runs of random length, released in between.
  initial begin
    int unsigned stall_len;
    forever begin
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin
    #100_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int unsigned start_count, wait_cycles;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // CR closing an indentation, spaces after it, extreme bytes, tabs inside the
    // indentation, and spaces still pending when the text ends.
    text_q = '{ChSpace, ChSpace, ChSpace, ChSpace, ChCr, ChSpace, 8'hFF, ChLf,
               ChTab, ChSpace, ChSpace, ChSpace, ChSpace, ChTab, 8'h00, ChLf,
               ChSpace, ChSpace};
    send_text();
    // Inconsistent indentation; later bytes are ignored.
    text_q = '{ChSpace, ChSpace, 8'h78, 8'h79};
    send_text();
    // The error falls on the last byte of the text.
    text_q = '{ChSpace, 8'h41};
    send_text();
    // LF closing an indentation.
    text_q = '{ChSpace, ChSpace, ChSpace, ChSpace, ChLf};
    send_text();

    // Deepest legal indentation, then one deep enough to saturate the count.
    text_q.delete();
    repeat (4 * MaxTabs) text_q.push_back(ChSpace);
    text_q.push_back(8'h7A);
    text_q.push_back(ChLf);
    repeat (4 * MaxTabs + 8) text_q.push_back(ChSpace);
    text_q.push_back(8'h79);
    send_text();

    start_count = items_sent;
    while (items_sent - start_count < RandomItems) begin
      quiet = ($urandom_range(0, 7) == 0);
      build_text();
      send_text();
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < WaitLimit) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ist_pkg.sv
rtl/core/ist_front.sv
rtl/core/ist_fifo.sv
rtl/core/ist_back.sv
rtl/core/indent_spaces_to_tabs.sv
tb/sv/ist_checker.sv
tb/sv/tb_top.sv
